// ----- hw/rtl/lrupr_pkg.sv -----
`default_nettype none

package lrupr_pkg;

  localparam int MAX_FRAMES = 16;
  localparam int PAGE_BITS  = 16;
  localparam int IDX_W      = $clog2(MAX_FRAMES);
  localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
  localparam int CFG_W      = 5;
  localparam int FAULT_W    = 32;

  localparam logic [CFG_W-1:0]   FRAMES_RESET = CFG_W'(4);
  localparam logic [FAULT_W-1:0] FAULT_MAX    = {FAULT_W{1'b1}};

  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  // One write into the recency stack.
  typedef struct packed {
    logic  en;
    idx_t  addr;
    page_t data;
  } stack_wr_t;

  // Finished outcome of one reference.
  typedef struct packed {
    logic               hit;
    logic               ev_valid;
    page_t              ev_page;
    logic [FAULT_W-1:0] faults;
  } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lrupr_stack.sv -----
`default_nettype none

module lrupr_stack (
  input  wire logic              clk,
  input  wire lrupr_pkg::idx_t   rd_addr,
  output lrupr_pkg::page_t       rd_data,
  input  wire lrupr_pkg::stack_wr_t wr
);
  import lrupr_pkg::*;

  // Entry 0 is the most recent page. Only entries below the resident count
  // are ever read, so no reset is needed.
  page_t entries [MAX_FRAMES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      entries[wr.addr] <= wr.data;
    end
  end

  assign rd_data = entries[rd_addr];

endmodule

`default_nettype wire

// ----- hw/rtl/lrupr_ctrl.sv -----
`default_nettype none

module lrupr_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire lrupr_pkg::page_t        start_page,
  input  wire logic [lrupr_pkg::CFG_W-1:0] frames_cfg,
  input  wire logic                    out_free,
  output logic                         idle,
  output logic                         done,
  output lrupr_pkg::result_t           result,
  output lrupr_pkg::idx_t              rd_addr,
  input  wire lrupr_pkg::page_t        rd_data,
  output lrupr_pkg::stack_wr_t         wr
);
  import lrupr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT
  } state_t;

  state_t             state;
  page_t              page;
  cnt_t               cap;
  idx_t               idx;
  idx_t               shift_pos;
  cnt_t               resident;
  logic [FAULT_W-1:0] faults;
  logic               hit;
  logic               ev_valid;
  page_t              ev_page;

  cnt_t cap_next;
  logic match;
  logic last;
  logic finish;

  // Clamp the configured frame count into 1..MAX_FRAMES.
  always_comb begin
    if (frames_cfg == '0) begin
      cap_next = cnt_t'(1);
    end else if ({{(CNT_W + CFG_W){1'b0}}, frames_cfg} >
                 (CNT_W + CFG_W + CFG_W)'(MAX_FRAMES)) begin
      cap_next = cnt_t'(MAX_FRAMES);
    end else begin
      cap_next = cnt_t'(frames_cfg);
    end
  end

  // The shared compare unit looks at one stack entry per cycle.
  assign match  = (resident != '0) && (rd_data == page);
  assign last   = (cnt_t'(idx) + cnt_t'(1)) >= resident;
  assign finish = (state == ST_SHIFT) && (shift_pos == '0) && out_free;

  assign rd_addr = (state == ST_SHIFT) ? idx_t'(shift_pos - idx_t'(1)) : idx;
  assign idle    = (state == ST_IDLE);
  assign done    = finish;

  always_comb begin
    wr.en   = 1'b0;
    wr.addr = shift_pos;
    wr.data = rd_data;
    if (state == ST_SHIFT) begin
      if (shift_pos != '0) begin
        wr.en = 1'b1;
      end else if (out_free) begin
        wr.en   = 1'b1;
        wr.data = page;
      end
    end
  end

  assign result.hit      = hit;
  assign result.ev_valid = ev_valid;
  assign result.ev_page  = ev_page;
  assign result.faults   = faults;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      resident  <= '0;
      faults    <= '0;
      idx       <= '0;
      shift_pos <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            page     <= start_page;
            cap      <= cap_next;
            idx      <= '0;
            hit      <= 1'b0;
            ev_valid <= 1'b0;
            ev_page  <= '0;
            state    <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (match) begin
            hit       <= 1'b1;
            shift_pos <= idx;
            state     <= ST_SHIFT;
          end else if ((resident == '0) || last) begin
            if (resident < cap) begin
              shift_pos <= idx_t'(resident);
              resident  <= resident + cnt_t'(1);
            end else begin
              // All frames are taken: the bottom entry, read this cycle, goes.
              ev_valid  <= 1'b1;
              ev_page   <= rd_data;
              shift_pos <= idx_t'(resident - cnt_t'(1));
            end
            if (faults != FAULT_MAX) begin
              faults <= faults + FAULT_W'(1);
            end
            state <= ST_SHIFT;
          end else begin
            idx <= idx + idx_t'(1);
          end
        end
        ST_SHIFT: begin
          if (shift_pos != '0) begin
            shift_pos <= shift_pos - idx_t'(1);
          end else if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lru_page_replacement.sv -----
`default_nettype none

// Channel   | Dir | Signals                      | Contents
// s_axis    | in  | tvalid, tready, tdata[15:0]  | requested_page
// m_axis    | out | tvalid, tready, tdata[55:0]  | hit, evicted_valid, evicted_page,
//           |     |                              | fault_count
// cfg       | in  | cfg_we, cfg_wdata[4:0]       | frames_in_use
//
// A reference is handled in steps: it is accepted while idle, the single page
// comparator then checks the stack entries from the top until a hit or the
// last resident entry, and the stack then shifts one entry per cycle down to
// the position being refilled before the new page is written into entry 0.
// Synchronous reset empties the stack, zeroes the fault count and sets the
// frame count to 4. A result word waits in the output register while the
// next reference is already being worked on; only the final stack write
// waits for that register to free up.

module lru_page_replacement (
  input  wire logic        clk,
  input  wire logic        rst,
  // Reference input.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] requested_page
  // Result output.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,   // [0] hit, [1] evicted_valid,
                                           // [17:2] evicted_page,
                                           // [49:18] fault_count, rest zero
  // Frame count register.
  input  wire logic        cfg_we,
  input  wire logic [4:0]  cfg_wdata
);
  import lrupr_pkg::*;

  logic [CFG_W-1:0] frames_in_use;
  logic             idle;
  logic             done;
  logic             out_free;
  result_t          result;
  result_t          out_word;
  idx_t             rd_addr;
  page_t            rd_data;
  stack_wr_t        wr;

  // The user must write the frame count register only while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= FRAMES_RESET;
    end else if (cfg_we) begin
      frames_in_use <= cfg_wdata;
    end
  end

  assign s_axis_tready = idle;

  // The output register can take a new word when empty or being drained.
  assign out_free = !m_axis_tvalid || m_axis_tready;

  lrupr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (s_axis_tvalid && s_axis_tready),
    .start_page (page_t'(s_axis_tdata)),
    .frames_cfg (frames_in_use),
    .out_free   (out_free),
    .idle       (idle),
    .done       (done),
    .result     (result),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .wr         (wr)
  );

  lrupr_stack u_stack (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (wr)
  );

  // Output register: the finished word is held here until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (done) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_word <= result;
    end
  end

  assign m_axis_tdata = {6'd0, out_word.faults, 16'(out_word.ev_page),
                         out_word.ev_valid, out_word.hit};

endmodule

`default_nettype wire

// ----- hw/rtl/lrupr_checker.sv -----
`default_nettype none

module lrupr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [55:0] m_axis_tdata
);

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result word changed while stalled");

  // A hit never evicts.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[0]) |-> !m_axis_tdata[1])
    else $error("hit reported together with an eviction");

  // The evicted page reads zero when nothing was evicted.
  a_evict_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[1]) |-> (m_axis_tdata[17:2] == 16'd0))
    else $error("evicted page not zero without an eviction");

  // A fault always leaves a nonzero fault count.
  a_fault_count: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[49:18] != 32'd0))
    else $error("fault reported with a zero fault count");

  // A reference is still being worked on right after it is taken, so the input is not ready then.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken again right after an accept");

endmodule

bind lru_page_replacement lrupr_checker u_lrupr_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
